@@ hdl/bba_pkg.sv @@
// Shared types, constants and control/status bundles for the buddy block allocator.
// Used by bba_ctrl, bba_dpath and buddy_block_allocator; depends on nothing else.
package bba_pkg;

    // Tree geometry: node 1 (one-based) is the root, node p has children 2p and 2p+1
    localparam int MAX_LEVEL  = 10;
    localparam int SIZE_W     = 16;
    localparam int NODE_W     = MAX_LEVEL + 1;
    localparam int MEM_DEPTH  = 2 ** NODE_W;
    localparam int LVL_W      = $clog2(MAX_LEVEL + 1);
    localparam int STATUS_W   = 2;
    localparam int OUT_W      = 16;
    localparam int OUT_PAD_W  = OUT_W - STATUS_W - NODE_W;

    localparam logic [SIZE_W-1:0] TOTAL_RESET = SIZE_W'(1024);

    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [NODE_W-1:0] node_t;
    typedef logic [LVL_W-1:0]  lvl_t;

    // Per-node tree state
    typedef enum logic [1:0] {
        NS_FREE  = 2'd0,
        NS_DIV   = 2'd1,
        NS_ALLOC = 2'd2
    } nstate_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        RS_OK      = 2'd0,
        RS_BADSIZE = 2'd1,
        RS_FULL    = 2'd2,
        RS_NOMATCH = 2'd3
    } res_t;

    // Operation carried on tuser
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr_step;
        logic start;
        logic lvl_step;
        logic descend;
        logic sibling;
        logic ascend;
        logic take_best;
        logic goto_leaf;
        logic goto_best;
        logic wr_alloc;
        logic wr_div;
        logic wr_free;
        logic rd_sib;
        logic set_res;
        res_t res_code;
    } ctl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic    clr_done;
        logic    req_bad;
        logic    lvl_more;
        logic    p_root;
        logic    p_odd;
        logic    dep_at_lvl;
        logic    dep_below_max;
        logic    best_valid;
        logic    p_better;
        logic    size_match;
        nstate_t rd_state;
    } sts_t;

endpackage

@@ hdl/bba_dpath.sv @@
// Datapath of the buddy block allocator: walk pointer, level search, node memories.
// Depends on bba_pkg; driven by bba_ctrl through ctl_t and answers with sts_t.
module bba_dpath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bba_pkg::ctl_t         ctl,
    input  bba_pkg::size_t        total_size,
    input  bba_pkg::size_t        req_in,
    output bba_pkg::sts_t         sts,
    output bba_pkg::res_t         res_status,
    output bba_pkg::node_t        res_node
);
    import bba_pkg::*;

    // Node memories, indexed by one-based node number (entry 0 unused)
    nstate_t state_mem [MEM_DEPTH];
    size_t   size_mem  [MEM_DEPTH];

    nstate_t rd_state_reg;
    size_t   rd_size_reg;

    node_t   clr_cnt_reg, clr_cnt_next;
    node_t   p_reg, p_next;
    node_t   best_reg, best_next;
    lvl_t    dep_reg, dep_next;
    lvl_t    lvl_reg, lvl_next;
    size_t   req_reg, req_next;
    size_t   shift_reg, shift_next;
    res_t    res_status_reg, res_status_next;
    node_t   res_node_reg, res_node_next;

    node_t   leaf;
    node_t   raddr;
    node_t   waddr;
    nstate_t wdata;
    logic    we;

    // Leftmost descendant of p at the target level
    assign leaf = node_t'(p_reg << (lvl_reg - dep_reg));

    // Pick read and write addresses
    assign raddr = ctl.rd_sib ? (p_reg ^ node_t'(1)) : p_reg;
    assign we    = ctl.clr_step | ctl.wr_alloc | ctl.wr_div | ctl.wr_free;
    assign waddr = ctl.clr_step ? clr_cnt_reg : p_reg;

    always_comb
    begin
        priority if (ctl.wr_alloc)
            wdata = NS_ALLOC;
        else if (ctl.wr_div)
            wdata = NS_DIV;
        else
            wdata = NS_FREE;
    end

    // Node state and size memories, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            state_mem[waddr] <= wdata;
        if (ctl.wr_alloc)
            size_mem[p_reg] <= req_reg;
        rd_state_reg <= state_mem[raddr];
        rd_size_reg  <= size_mem[raddr];
    end

    // Next values of the walk registers
    always_comb
    begin
        clr_cnt_next    = ctl.clr_step ? clr_cnt_reg + node_t'(1) : clr_cnt_reg;
        p_next          = p_reg;
        dep_next        = dep_reg;
        best_next       = best_reg;
        lvl_next        = lvl_reg;
        shift_next      = shift_reg;
        req_next        = req_reg;
        res_status_next = res_status_reg;
        res_node_next   = res_node_reg;

        if (ctl.start)
        begin
            p_next     = node_t'(1);
            dep_next   = '0;
            best_next  = '0;
            lvl_next   = '0;
            shift_next = total_size;
            req_next   = req_in;
        end
        else if (ctl.descend)
        begin
            p_next   = {p_reg[NODE_W-2:0], 1'b0};
            dep_next = dep_reg + lvl_t'(1);
        end
        else if (ctl.sibling)
            p_next = p_reg + node_t'(1);
        else if (ctl.ascend)
        begin
            p_next   = p_reg >> 1;
            dep_next = dep_reg - lvl_t'(1);
        end
        else if (ctl.goto_leaf)
        begin
            p_next    = leaf;
            best_next = leaf;
            dep_next  = lvl_reg;
        end
        else if (ctl.goto_best)
            p_next = best_reg;
        else if (ctl.take_best)
            best_next = p_reg;
        else if (ctl.lvl_step)
        begin
            lvl_next   = lvl_reg + lvl_t'(1);
            shift_next = shift_reg >> 1;
        end

        // Load the result register
        if (ctl.set_res)
        begin
            res_status_next = ctl.res_code;
            res_node_next   = (ctl.res_code == RS_OK) ? best_reg - node_t'(1) : '0;
        end
    end

    // Clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else
            clr_cnt_reg <= clr_cnt_next;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        p_reg          <= p_next;
        dep_reg        <= dep_next;
        best_reg       <= best_next;
        lvl_reg        <= lvl_next;
        shift_reg      <= shift_next;
        req_reg        <= req_next;
        res_status_reg <= res_status_next;
        res_node_reg   <= res_node_next;
    end

    // Status back to the controller
    always_comb
    begin
        sts.clr_done      = &clr_cnt_reg;
        sts.req_bad       = (req_reg == '0) || (req_reg > total_size);
        sts.lvl_more      = (lvl_reg < lvl_t'(MAX_LEVEL)) && ((shift_reg >> 1) >= req_reg);
        sts.p_root        = (p_reg == node_t'(1));
        sts.p_odd         = p_reg[0];
        sts.dep_at_lvl    = (dep_reg == lvl_reg);
        sts.dep_below_max = (dep_reg < lvl_t'(MAX_LEVEL));
        sts.best_valid    = (best_reg != '0);
        sts.p_better      = (best_reg == '0) || (p_reg < best_reg);
        sts.size_match    = (rd_size_reg == req_reg);
        sts.rd_state      = rd_state_reg;
    end

    assign res_status = res_status_reg;
    assign res_node   = res_node_reg;

endmodule

@@ hdl/bba_ctrl.sv @@
// Controller of the buddy block allocator: clearing pass, level search, tree walk,
// marking and merging. Depends on bba_pkg; drives bba_dpath through ctl_t.
module bba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_op,
    output logic          in_ready,
    input  logic          out_ready,
    output logic          out_valid,
    input  bba_pkg::sts_t sts,
    output bba_pkg::ctl_t ctl
);
    import bba_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_LVL,
        S_WRD,
        S_WEV,
        S_WADV,
        S_AMARK,
        S_AUP,
        S_ADIV,
        S_FWFREE,
        S_FSRD,
        S_FSEV,
        S_RES
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    res_t   code_reg, code_next;
    logic   out_vld_reg, out_vld_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_vld_reg;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        code_next    = code_reg;
        ctl          = '0;
        ctl.res_code = code_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.start = 1'b1;
                    op_next   = op_t'(in_op);
                    if (op_t'(in_op) == OP_FREE)
                        state_next = S_WRD;
                    else
                        state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.req_bad)
                begin
                    code_next  = RS_BADSIZE;
                    state_next = S_RES;
                end
                else
                    state_next = S_LVL;
            end
            // Find the deepest level whose block still holds the request
            S_LVL:
            begin
                if (sts.lvl_more)
                    ctl.lvl_step = 1'b1;
                else
                    state_next = S_WRD;
            end
            S_WRD:
                state_next = S_WEV;
            // Judge the node just read
            S_WEV:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (sts.dep_at_lvl)
                    begin
                        if (sts.rd_state == NS_FREE)
                        begin
                            ctl.take_best = 1'b1;
                            state_next    = S_AMARK;
                        end
                        else
                            state_next = S_WADV;
                    end
                    else
                    begin
                        unique case (sts.rd_state)
                            NS_FREE:
                            begin
                                // whole subtree free: take its leftmost block
                                ctl.goto_leaf = 1'b1;
                                state_next    = S_AMARK;
                            end
                            NS_DIV:
                            begin
                                ctl.descend = 1'b1;
                                state_next  = S_WRD;
                            end
                            default:
                                state_next = S_WADV;
                        endcase
                    end
                end
                else
                begin
                    unique case (sts.rd_state)
                        NS_ALLOC:
                        begin
                            if (sts.size_match && sts.p_better)
                                ctl.take_best = 1'b1;
                            state_next = S_WADV;
                        end
                        NS_DIV:
                        begin
                            // descendants only beat the best match if p does
                            if (sts.p_better && sts.dep_below_max)
                            begin
                                ctl.descend = 1'b1;
                                state_next  = S_WRD;
                            end
                            else
                                state_next = S_WADV;
                        end
                        default:
                            state_next = S_WADV;
                    endcase
                end
            end
            // Move to the next subtree in left-to-right order
            S_WADV:
            begin
                if (sts.p_root)
                begin
                    if (op_reg == OP_ALLOC)
                    begin
                        code_next  = RS_FULL;
                        state_next = S_RES;
                    end
                    else if (sts.best_valid)
                    begin
                        ctl.goto_best = 1'b1;
                        state_next    = S_FWFREE;
                    end
                    else
                    begin
                        code_next  = RS_NOMATCH;
                        state_next = S_RES;
                    end
                end
                else if (sts.p_odd)
                    ctl.ascend = 1'b1;
                else
                begin
                    ctl.sibling = 1'b1;
                    state_next  = S_WRD;
                end
            end
            S_AMARK:
            begin
                ctl.wr_alloc = 1'b1;
                state_next   = S_AUP;
            end
            // Mark every ancestor as divided
            S_AUP:
            begin
                if (sts.p_root)
                begin
                    code_next  = RS_OK;
                    state_next = S_RES;
                end
                else
                begin
                    ctl.ascend = 1'b1;
                    state_next = S_ADIV;
                end
            end
            S_ADIV:
            begin
                ctl.wr_div = 1'b1;
                state_next = S_AUP;
            end
            // Free the node, then merge upward while the buddy is free
            S_FWFREE:
            begin
                ctl.wr_free = 1'b1;
                state_next  = S_FSRD;
            end
            S_FSRD:
            begin
                if (sts.p_root)
                begin
                    code_next  = RS_OK;
                    state_next = S_RES;
                end
                else
                begin
                    ctl.rd_sib = 1'b1;
                    state_next = S_FSEV;
                end
            end
            S_FSEV:
            begin
                if (sts.rd_state == NS_FREE)
                begin
                    ctl.ascend = 1'b1;
                    state_next = S_FWFREE;
                end
                else
                begin
                    code_next  = RS_OK;
                    state_next = S_RES;
                end
            end
            // Hand the word to the output register once it has room
            S_RES:
            begin
                if (!out_vld_reg || out_ready)
                begin
                    ctl.set_res = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Output valid: set on load, drop once taken
    always_comb
    begin
        if (ctl.set_res)
            out_vld_next = 1'b1;
        else if (out_ready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            op_reg      <= OP_ALLOC;
            code_reg    <= RS_OK;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            code_reg    <= code_next;
            out_vld_reg <= out_vld_next;
        end
    end

endmodule

@@ hdl/buddy_block_allocator.sv @@
// Top level of the buddy block allocator: configuration register, output packing.
// Depends on bba_pkg, bba_ctrl and bba_dpath.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser: cmd; tdata: request_size
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: status, node_index
//  cfg       in   cfg_valid/cfg_ready           cfg_data: total_size
//
// After reset a clearing pass marks all 2048 node entries free, one per cycle, while
// s_axis_tready is low; total_size resets to 1024. One word is worked at a time; the node
// memory has one registered read, so each visited node takes a read and an evaluate state,
// and each step to a sibling or up to a parent an advance state. Allocate adds a size
// check, a level search and ancestor marking; free adds a write, a buddy read and a check
// per merge step. A result waiting on m_axis does not block the next input word.
module buddy_block_allocator (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // [15:0] request_size
    input  logic                  s_axis_tuser,   // [0] cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // [1:0] status, [12:2] node_index, [15:13] 0
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [15:0]           cfg_data        // [15:0] total_size
);
    import bba_pkg::*;

    size_t total_size_reg, total_size_next;
    ctl_t  ctl;
    sts_t  sts;
    res_t  res_status;
    node_t res_node;

    // Configuration register, always ready
    assign cfg_ready       = 1'b1;
    assign total_size_next = cfg_valid ? size_t'(cfg_data) : total_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_size_reg <= TOTAL_RESET;
        else
            total_size_reg <= total_size_next;
    end

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_op     (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .sts       (sts),
        .ctl       (ctl)
    );

    bba_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .total_size (total_size_reg),
        .req_in     (size_t'(s_axis_tdata)),
        .sts        (sts),
        .res_status (res_status),
        .res_node   (res_node)
    );

    // Pack the result word
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res_node, res_status};

endmodule

@@ bench/bba_grant_checker.sv @@
// Checker for the buddy block allocator: watches the request, result and config channels,
// keeps its own copy of the block tree and compares every result word with its prediction.
// Depends on bba_pkg for the tree geometry, node states, status codes and operations.
module bba_grant_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] request_size
    input  logic        s_axis_tuser,   // [0] cmd
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [1:0] status, [12:2] node_index, [15:13] 0
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,       // [15:0] total_size
    output int          outstanding,
    output int          mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    localparam int NODE_COUNT = MEM_DEPTH - 1;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        res_t  status;
        node_t node;
    } grant_t;

    nstate_t tree_state [NODE_COUNT];
    size_t   held_size  [NODE_COUNT];
    size_t   root_size;
    grant_t  awaited_grants [$];
    int      fault_count;

    // Place a request at the deepest level that still holds it, leftmost node first
    task automatic predict_allocate(input size_t req, output res_t code, output node_t where);
        int  lvl;
        int  n;
        int  a;
        bit  clear;
        bit  done;
        code  = RS_FULL;
        where = '0;
        done  = 1'b0;
        if (req == '0 || req > root_size) begin
            code = RS_BADSIZE;
        end
        else begin
            lvl = 0;
            while (lvl < MAX_LEVEL && (root_size >> (lvl + 1)) >= req)
                lvl++;
            for (n = (1 << lvl) - 1; n <= (2 << lvl) - 2 && !done; n++) begin
                if (tree_state[n] == NS_FREE) begin
                    // reject a node that sits inside an allocated block
                    clear = 1'b1;
                    a = n;
                    while (a != 0) begin
                        a = (a - 1) >> 1;
                        if (tree_state[a] == NS_ALLOC)
                            clear = 1'b0;
                    end
                    if (clear) begin
                        tree_state[n] = NS_ALLOC;
                        held_size[n]  = req;
                        a = n;
                        while (a != 0) begin
                            a = (a - 1) >> 1;
                            tree_state[a] = NS_DIV;
                        end
                        code  = RS_OK;
                        where = node_t'(n);
                        done  = 1'b1;
                    end
                end
            end
        end
    endtask

    // Release the lowest-numbered allocation of this size, then merge free buddies upward
    task automatic predict_release(input size_t req, output res_t code, output node_t where);
        int n;
        int hit;
        int sib;
        bit merging;
        hit = -1;
        for (n = 0; n < NODE_COUNT && hit < 0; n++)
            if (tree_state[n] == NS_ALLOC && held_size[n] == req)
                hit = n;
        if (hit < 0) begin
            code  = RS_NOMATCH;
            where = '0;
        end
        else begin
            tree_state[hit] = NS_FREE;
            n = hit;
            merging = 1'b1;
            while (n != 0 && merging) begin
                sib = (n % 2 == 1) ? n + 1 : n - 1;
                if (tree_state[n] == NS_FREE && tree_state[sib] == NS_FREE) begin
                    n = (n - 1) >> 1;
                    tree_state[n] = NS_FREE;
                end
                else
                    merging = 1'b0;
            end
            code  = RS_OK;
            where = node_t'(hit);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : track_channels
        grant_t want;
        res_t   code;
        node_t  where;
        int     n;
        if (!rst_n) begin
            root_size = TOTAL_RESET;
            for (n = 0; n < NODE_COUNT; n++) begin
                tree_state[n] = NS_FREE;
                held_size[n]  = '0;
            end
            awaited_grants.delete();
            fault_count = 0;
        end
        else begin
            // compare a result word with the oldest prediction before adding a new one
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_grants.size() == 0) begin
                    if (fault_count < REPORT_MAX)
                        $display("%0t: result word %h with no request waiting",
                                 $realtime, m_axis_tdata);
                    fault_count++;
                end
                else begin
                    want = awaited_grants.pop_front();
                    if (m_axis_tdata[1:0] != want.status ||
                        m_axis_tdata[12:2] != want.node ||
                        m_axis_tdata[15:13] != 3'b000) begin
                        if (fault_count < REPORT_MAX)
                            $display("%0t: status exp %0d got %0d, node exp %0d got %0d, pad %0d",
                                     $realtime, want.status, m_axis_tdata[1:0],
                                     want.node, m_axis_tdata[12:2], m_axis_tdata[15:13]);
                        fault_count++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
                root_size = cfg_data;

            // predict the result of each accepted request word
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == OP_ALLOC)
                    predict_allocate(s_axis_tdata, code, where);
                else
                    predict_release(s_axis_tdata, code, where);
                want.status = code;
                want.node   = where;
                awaited_grants.push_back(want);
            end
        end
        outstanding <= awaited_grants.size();
        mismatches  <= fault_count;
    end

endmodule

@@ bench/tb_buddy_block_allocator.sv @@
// Top of the buddy block allocator bench: clock, reset, request and config stimulus, verdict.
// Depends on bba_pkg, the buddy_block_allocator RTL and bba_grant_checker.
module tb_buddy_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    // Worst item: a full scan of the tree plus merges, taken several times
    localparam int CYCLE_LIMIT   = 40_000_000;
    localparam int PHASE_WORDS   = 225;
    localparam int PHASE_COUNT   = 6;
    localparam int LIVE_CAP      = 14;
    localparam int HOLD_AFTER    = 300;
    localparam int HOLD_CYCLES   = 1500;
    localparam int SETTLE_CYCLES = 64;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data      = '0;

    int    outstanding;
    int    mismatches;
    int    cycle_count   = 0;
    int    send_idle_pct = 25;
    int    take_idle_pct = 61;
    size_t live_sizes [$];

    buddy_block_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    bba_grant_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .outstanding   (outstanding),
        .mismatches    (mismatches)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort a run that has hung
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Take result words with random stalls, and once hold off long enough to back up the input
    initial
    begin : result_sink
        int taken;
        bit held;
        taken = 0;
        held  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                taken++;
            if (!held && taken >= HOLD_AFTER)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= take_idle_pct);
        end
    end

    // Offer one request word after a random gap and hold it until accepted
    task automatic send_word(input op_t op, input size_t size);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= size;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write total_size with the block idle
    task automatic write_total(input size_t value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int    p;
        int    i;
        int    k;
        int    roll;
        int    free_pct;
        size_t sz;
        size_t total;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // zero and oversized requests, whole-memory fit, full level, unmatched frees
        send_word(OP_ALLOC, 16'd0);
        send_word(OP_ALLOC, 16'd1025);
        send_word(OP_ALLOC, 16'hFFFF);
        send_word(OP_ALLOC, 16'd1024);
        send_word(OP_ALLOC, 16'd1);
        send_word(OP_FREE,  16'd1024);
        send_word(OP_FREE,  16'd1024);
        send_word(OP_FREE,  16'd0);
        // exact fit at level one, then small blocks beside it and a level left full
        send_word(OP_ALLOC, 16'd512);
        send_word(OP_ALLOC, 16'd1);
        send_word(OP_ALLOC, 16'd300);
        send_word(OP_ALLOC, 16'd3);
        send_word(OP_FREE,  16'd1);
        send_word(OP_FREE,  16'd512);
        send_word(OP_FREE,  16'd3);
        // buddies of one size, freed again so they merge back up
        send_word(OP_ALLOC, 16'd2);
        send_word(OP_ALLOC, 16'd2);
        send_word(OP_ALLOC, 16'd2);
        send_word(OP_FREE,  16'd2);
        send_word(OP_FREE,  16'd2);
        send_word(OP_FREE,  16'd2);

        // zero memory refuses every allocation
        write_total(16'd0);
        send_word(OP_ALLOC, 16'd1);
        send_word(OP_FREE,  16'd1);

        // largest memory takes the largest request at the root
        write_total(16'hFFFF);
        send_word(OP_ALLOC, 16'hFFFF);
        send_word(OP_FREE,  16'hFFFF);

        // random phases over several memory sizes and idling patterns
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       total = 16'd1024;
                1:       total = 16'hFFFF;
                2:       total = 16'd16;
                3:       total = 16'd1;
                4:       total = size_t'($urandom_range(2, 4095));
                default: total = 16'd1024;
            endcase
            send_idle_pct = (p < 2) ? 25 : (p < 4) ? 61 : 0;
            take_idle_pct = (p < 2) ? 61 : (p < 4) ? 25 : 0;
            write_total(total);

            for (i = 0; i < PHASE_WORDS; i++)
            begin
                free_pct = (live_sizes.size() > LIVE_CAP) ? 75 : 40;
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    send_word(op_t'($urandom_range(0, 1)), size_t'($urandom));
                else if (roll < 8 + free_pct * 92 / 100 && live_sizes.size() > 0)
                begin
                    // release a size that was requested earlier
                    k = $urandom_range(0, live_sizes.size() - 1);
                    sz = live_sizes[k];
                    live_sizes.delete(k);
                    send_word(OP_FREE, sz);
                end
                else
                begin
                    // favour block sizes exactly, otherwise anything up to a block size
                    sz = total >> $urandom_range(0, MAX_LEVEL);
                    if ($urandom_range(0, 3) != 0)
                        sz = size_t'($urandom_range(1, (sz == '0) ? 1 : sz));
                    live_sizes.push_back(sz);
                    send_word(OP_ALLOC, sz);
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
